// ===== sv/cir_sample_magnitude_defines.svh =====
// assertion helpers for the sample magnitude block
`ifndef CIR_SAMPLE_MAGNITUDE_DEFINES_SVH
`define CIR_SAMPLE_MAGNITUDE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define CSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define CSM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/csm_pkg.sv =====
`default_nettype none

package csm_pkg;

  localparam int unsigned PART_W        = 24;
  localparam int unsigned SHORT_W       = 16;
  localparam int unsigned SUM_W         = 2 * PART_W;
  localparam int unsigned OUT_W         = 32;
  localparam int unsigned FRAC_BITS_DEF = 8;

  // magnitude of one signed part, full or short width
  function automatic logic [PART_W-1:0] part_mag(input logic [PART_W-1:0] raw,
                                                 input logic               full);
    logic [PART_W-1:0]  neg_full;
    logic [SHORT_W-1:0] neg_short;
    logic [PART_W-1:0]  res;
    neg_full  = PART_W'(0) - raw;
    neg_short = SHORT_W'(0) - raw[SHORT_W-1:0];
    if (full) begin
      res = raw[PART_W-1] ? neg_full : raw;
    end else begin
      res = raw[SHORT_W-1] ? PART_W'(neg_short) : PART_W'(raw[SHORT_W-1:0]);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/csm_front.sv =====
`default_nettype none

module csm_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       full_mode_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [csm_pkg::PART_W-1:0] real_raw_i,
  input  wire logic [csm_pkg::PART_W-1:0] imag_raw_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [csm_pkg::SUM_W-1:0]       out_sum_o
);
  import csm_pkg::*;

  logic              v1_q, v2_q, v3_q;
  logic              rdy1, rdy2, rdy3;
  logic [PART_W-1:0] mre_q, mim_q;
  logic [SUM_W-1:0]  sqre_q, sqim_q;
  logic [SUM_W-1:0]  sum_q;

  // a stage moves when empty or when its successor takes its data
  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  // part magnitudes, then squares, then the sum
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      mre_q <= part_mag(real_raw_i, full_mode_i);
      mim_q <= part_mag(imag_raw_i, full_mode_i);
    end
    if (rdy2 && v1_q) begin
      sqre_q <= SUM_W'(mre_q) * SUM_W'(mre_q);
      sqim_q <= SUM_W'(mim_q) * SUM_W'(mim_q);
    end
    if (rdy3 && v2_q) begin
      sum_q <= sqre_q + sqim_q;
    end
  end

  assign out_valid_o = v3_q;
  assign out_sum_o   = sum_q;

endmodule

`default_nettype wire

// ===== sv/csm_cell.sv =====
`default_nettype none

module csm_cell #(
  parameter int unsigned ROOT_W = csm_pkg::PART_W + csm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [csm_pkg::SUM_W-1:0] in_sum_i,
  input  wire logic [ROOT_W+1:0]         in_rem_i,
  input  wire logic [ROOT_W-1:0]         in_root_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [csm_pkg::SUM_W-1:0]      out_sum_o,
  output logic [ROOT_W+1:0]              out_rem_o,
  output logic [ROOT_W-1:0]              out_root_o
);
  import csm_pkg::*;

  localparam int unsigned REM_W = ROOT_W + 2;

  logic             valid_q;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [REM_W-1:0] rem_sh, trial;
  logic             take;

  assign in_ready_o = !valid_q || out_ready_i;

  // one restoring step: bring down the next pair, try 4*root+1
  always_comb begin
    rem_sh = {in_rem_i[REM_W-3:0], in_sum_i[SUM_W-1 -: 2]};
    trial  = {in_root_i, 2'b01};
    take   = rem_sh >= trial;
    rem_d  = take ? (rem_sh - trial) : rem_sh;
    root_d = {in_root_i[ROOT_W-2:0], take};
    sum_d  = {in_sum_i[SUM_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      sum_q  <= sum_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_sum_o   = sum_q;
  assign out_rem_o   = rem_q;
  assign out_root_o  = root_q;

endmodule

`default_nettype wire

// ===== sv/cir_sample_magnitude.sv =====
`default_nettype none

`include "cir_sample_magnitude_defines.svh"

// Magnitude of one complex impulse response sample: floor(sqrt(re^2 + im^2) * 2^FRAC_BITS)
// as an unsigned 32-bit word, exact to the last bit. Parts are 24-bit two's complement when
// full_width_mode is 1 (its reset value) and the low 16 bits of each word when it is 0; the
// mode is to be changed only while no transaction is in flight, which the block itself does
// not enforce. The block takes one sample per clock unless backpressure has filled every
// stage, and gives one result per sample, in order. Part magnitudes, squares and the sum
// of squares are registered in turn, then a row of 24 + FRAC_BITS square root cells
// resolves one result bit per cell. Every stage holds its transaction under backpressure
// and empty stages close up, so up to 27 + FRAC_BITS samples can be buffered while the
// output waits. Above FRAC_BITS of 8 a root that does not fit in 32 bits saturates to all
// ones.
module cir_sample_magnitude #(
  parameter int unsigned FRAC_BITS = csm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [csm_pkg::PART_W-1:0] real_raw_i,
  input  wire logic [csm_pkg::PART_W-1:0] imag_raw_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [csm_pkg::OUT_W-1:0]       magnitude_o
);
  import csm_pkg::*;

  // one cell per root bit: 24 integer bits plus the fraction bits
  localparam int unsigned ROOT_W = PART_W + FRAC_BITS;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned NCELL  = ROOT_W;

  logic full_mode_q;

  // chain buses: index 0 is the front end output, index k the output of cell k-1
  logic [NCELL:0]                  cell_valid;
  logic [NCELL:0]                  cell_ready;
  logic [NCELL:0][SUM_W-1:0]       cell_sum;
  logic [NCELL:0][REM_W-1:0]       cell_rem;
  logic [NCELL:0][ROOT_W-1:0]      cell_root;
  logic [ROOT_W-1:0]               root_out;

  // mode register, written without handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      full_mode_q <= cfg_wdata_i;
    end
  end

  // part magnitudes, squares and sum of squares
  csm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .full_mode_i (full_mode_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .real_raw_i  (real_raw_i),
    .imag_raw_i  (imag_raw_i),
    .out_valid_o (cell_valid[0]),
    .out_ready_i (cell_ready[0]),
    .out_sum_o   (cell_sum[0])
  );

  // the root starts from an empty remainder and root
  assign cell_rem[0]  = '0;
  assign cell_root[0] = '0;

  // the radicand shifts up two bits per cell; past the last pair zeros come in,
  // which supplies the 2*FRAC_BITS fraction bits of the shifted radicand
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    csm_cell #(
      .ROOT_W (ROOT_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (cell_valid[k]),
      .in_ready_o  (cell_ready[k]),
      .in_sum_i    (cell_sum[k]),
      .in_rem_i    (cell_rem[k]),
      .in_root_i   (cell_root[k]),
      .out_valid_o (cell_valid[k+1]),
      .out_ready_i (cell_ready[k+1]),
      .out_sum_o   (cell_sum[k+1]),
      .out_rem_o   (cell_rem[k+1]),
      .out_root_o  (cell_root[k+1])
    );
  end

  // the last cell is the output register
  assign cell_ready[NCELL] = out_ready_i;
  assign out_valid_o       = cell_valid[NCELL];
  assign root_out          = cell_root[NCELL];

  // saturate only when the root can be wider than the output
  if (ROOT_W > OUT_W) begin : g_sat
    assign magnitude_o = (|root_out[ROOT_W-1:OUT_W]) ? '1 : root_out[OUT_W-1:0];
  end else begin : g_nosat
    assign magnitude_o = OUT_W'(root_out);
  end

  // the first cell can only refuse data when the whole row is full and the output stalled
  `CSM_ASSERT_IMP(a_row_full, !cell_ready[0], (&cell_valid[NCELL:1]) && !out_ready_i, "cell row stalled with a free slot")

  // a refused input means the front end holds a finished sum
  `CSM_ASSERT_IMP(a_front_full, !in_ready_o, cell_valid[0] && !cell_ready[0], "front end stalled while not full")

  // a sum refused by the row is kept for the next cycle
  `CSM_ASSERT_NXT(a_sum_held, cell_valid[0] && !cell_ready[0], cell_valid[0] && $stable(cell_sum[0]), "front end sum lost under stall")

endmodule

`default_nettype wire

// ===== test/magnitude_checker.sv =====
`timescale 1ns / 1ps

// watches both channels and the mode register, predicts every magnitude and
// compares results in order against the oldest prediction
module magnitude_checker #(
  parameter int unsigned FRAC_BITS = csm_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [csm_pkg::PART_W-1:0]      real_raw_i,
  input  logic [csm_pkg::PART_W-1:0]      imag_raw_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [csm_pkg::OUT_W-1:0]       magnitude_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o,
  output int unsigned                     checked_o
);

  typedef struct packed {
    logic [csm_pkg::PART_W-1:0] re;
    logic [csm_pkg::PART_W-1:0] im;
    logic [csm_pkg::OUT_W-1:0]  mag;
  } mag_expect_t;

  mag_expect_t pending_mags[$];
  logic        full_mode;
  int unsigned fails;
  int unsigned checks;

  // absolute value of one part, 24-bit or low-16-bit two's complement
  function automatic logic [csm_pkg::PART_W-1:0] part_abs(input logic [csm_pkg::PART_W-1:0] raw,
                                                           input logic full);
    logic signed [csm_pkg::PART_W:0] v;
    v = full ? {raw[23], raw} : {{9{raw[15]}}, raw[15:0]};
    if (v < 0) begin
      v = -v;
    end
    return v[csm_pkg::PART_W-1:0];
  endfunction

  // floor(sqrt(re^2 + im^2) * 2^FRAC_BITS), digit by digit over the shifted power
  function automatic logic [csm_pkg::OUT_W-1:0] expected_magnitude(
    input logic [csm_pkg::PART_W-1:0] re,
    input logic [csm_pkg::PART_W-1:0] im,
    input logic                       full
  );
    logic [csm_pkg::PART_W-1:0] a;
    logic [csm_pkg::PART_W-1:0] b;
    logic [47:0]                power;
    logic [95:0]                radicand;
    logic [63:0]                root;
    logic [63:0]                rest;
    logic [63:0]                trial;
    a        = part_abs(re, full);
    b        = part_abs(im, full);
    power    = 48'(a) * 48'(a) + 48'(b) * 48'(b);
    radicand = 96'(power) << (2 * FRAC_BITS);
    root     = '0;
    rest     = '0;
    for (int i = 47; i >= 0; i--) begin
      rest  = (rest << 2) | 64'(radicand[2*i +: 2]);
      trial = (root << 2) | 64'd1;
      if (rest >= trial) begin
        rest = rest - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    // only reachable above eight fraction bits
    return (root > 64'hFFFF_FFFF) ? '1 : root[31:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    mag_expect_t want;
    if (!rst_ni) begin
      full_mode = 1'b1;
      pending_mags.delete();
      fails        = 0;
      checks       = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_mags.size() == 0) begin
          $display("%0t ns: unexpected magnitude %h, expected none", $time, magnitude_i);
          fails++;
        end else begin
          want = pending_mags.pop_front();
          checks++;
          if (magnitude_i !== want.mag) begin
            $display("%0t ns: magnitude mismatch for re %h im %h: expected %h, actual %h",
                     $time, want.re, want.im, want.mag, magnitude_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        want.re  = real_raw_i;
        want.im  = imag_raw_i;
        want.mag = expected_magnitude(real_raw_i, imag_raw_i, full_mode);
        pending_mags.push_back(want);
      end
      if (cfg_we_i) begin
        full_mode = cfg_wdata_i;
      end
      fail_count_o <= fails;
      pending_o    <= pending_mags.size();
      checked_o    <= checks;
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MAG_FRAC     = csm_pkg::FRAC_BITS_DEF;
  // pipeline depth plus a margin, used once the last result is in
  localparam int unsigned DRAIN_CYCLES = 3 + 24 + MAG_FRAC + 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PHASE_ITEMS  = 175;

  logic                         clk_i;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_we_i    = 1'b0;
  logic                         cfg_wdata_i = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  logic [csm_pkg::PART_W-1:0]   real_raw_i  = '0;
  logic [csm_pkg::PART_W-1:0]   imag_raw_i  = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [csm_pkg::OUT_W-1:0]    magnitude_o;

  int unsigned mag_fail_count;
  int unsigned mags_pending;
  int unsigned mags_checked;
  int unsigned cycle_count = 0;

  // stimulus-side view of the mode register, for the random parts and the summary counts
  logic        full_now = 1'b1;
  // sender gaps on or off for the current stretch
  bit          idle_on  = 1'b1;
  // final stretch of the run: no idling on either side
  bit          quiet    = 1'b0;
  int unsigned n_full   = 0;
  int unsigned n_short  = 0;

  cir_sample_magnitude #(
    .FRAC_BITS (MAG_FRAC)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .real_raw_i  (real_raw_i),
    .imag_raw_i  (imag_raw_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .magnitude_o (magnitude_o)
  );

  magnitude_checker #(
    .FRAC_BITS (MAG_FRAC)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .real_raw_i   (real_raw_i),
    .imag_raw_i   (imag_raw_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .magnitude_i  (magnitude_o),
    .fail_count_o (mag_fail_count),
    .pending_o    (mags_pending),
    .checked_o    (mags_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d magnitudes outstanding", cycle_count, mags_pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: ready drops in random bursts, with stretches held high in
  // between, and stays high in the quiet stretch
  initial begin : result_sink
    @(posedge clk_i);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
  end

  // offer one sample and hold it until the transaction completes, then
  // maybe leave a gap before the next one
  task automatic send_sample(input logic [csm_pkg::PART_W-1:0] re,
                             input logic [csm_pkg::PART_W-1:0] im);
    real_raw_i <= re;
    imag_raw_i <= im;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (full_now) begin
      n_full++;
    end else begin
      n_short++;
    end
    if (!quiet && idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // stop sending and wait for every predicted magnitude to come out;
  // the checker's count is registered, hence the wait before each look
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (mags_pending != 0);
  endtask

  // the mode only changes with the pipeline empty
  task automatic write_mode(input logic full);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= full;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    full_now    = full;
  endtask

  // one random part: mostly uniform words, plus small values of either sign
  // and the corners of the active width; in short mode the ignored top byte
  // stays random
  function automatic logic [csm_pkg::PART_W-1:0] random_part(input logic full);
    logic [csm_pkg::PART_W-1:0] r;
    logic [csm_pkg::PART_W-1:0] m;
    logic [1:0]                 pick;
    r    = 24'($urandom);
    pick = 2'($urandom);
    case ($urandom_range(0, 7))
      0: begin
        m = 24'($urandom_range(0, 20));
        m = pick[0] ? -m : m;
        r = full ? m : {r[23:16], m[15:0]};
      end
      1: begin
        if (full) begin
          case (pick)
            2'd0:    r = 24'h7F_FFFF;
            2'd1:    r = 24'h80_0000;
            2'd2:    r = 24'h80_0001;
            default: r = 24'hFF_FFFF;
          endcase
        end else begin
          case (pick)
            2'd0:    r[15:0] = 16'h7FFF;
            2'd1:    r[15:0] = 16'h8000;
            2'd2:    r[15:0] = 16'h8001;
            default: r[15:0] = 16'hFFFF;
          endcase
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic random_phase(input int unsigned count, input bit hold_off);
    for (int unsigned i = 0; i < count; i++) begin
      // switch sender gaps on and off in stretches
      if (i % 60 == 0) begin
        idle_on = ($urandom_range(0, 2) != 0);
      end
      send_sample(random_part(full_now), random_part(full_now));
      // sender waits for the whole pipeline to empty mid-phase
      if (hold_off && i == count / 2) begin
        drain_results();
      end
    end
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full width straight from reset: zero, both extremes, mixed signs, a
    // pythagorean triple and alternating bit patterns
    send_sample(24'h00_0000, 24'h00_0000);
    send_sample(24'h7F_FFFF, 24'h7F_FFFF);
    send_sample(24'h80_0000, 24'h80_0000);
    send_sample(24'h80_0000, 24'h00_0000);
    send_sample(24'h00_0000, 24'h80_0000);
    send_sample(24'hFF_FFFF, 24'hFF_FFFF);
    send_sample(24'h7F_FFFF, 24'h80_0000);
    send_sample(24'h00_0003, 24'hFF_FFFC);
    send_sample(24'h00_0001, 24'h00_0000);
    send_sample(24'hAA_AAAA, 24'h55_5555);

    // short width: the top byte must be ignored, the low half is signed
    write_mode(1'b0);
    send_sample(24'hFF_8000, 24'hFF_8000);
    send_sample(24'h00_7FFF, 24'h00_7FFF);
    send_sample(24'hAB_8000, 24'h00_0000);
    send_sample(24'hFF_FFFF, 24'h12_FFFF);
    send_sample(24'h00_0000, 24'h00_0000);
    send_sample(24'hFF_7FFF, 24'h01_8000);
    send_sample(24'h5A_0003, 24'hA5_FFFC);
    send_sample(24'h80_0000, 24'h7F_0000);

    write_mode(1'b1);
    random_phase(PHASE_ITEMS, 1'b0);
    write_mode(1'b0);
    random_phase(PHASE_ITEMS, 1'b1);
    write_mode(1'b1);
    random_phase(PHASE_ITEMS, 1'b0);
    write_mode(1'b0);
    quiet = 1'b1;
    random_phase(PHASE_ITEMS, 1'b0);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d samples (%0d full width, %0d short width) over five mode changes,",
             n_full + n_short, n_full, n_short);
    $display("%0d magnitudes compared, %0d mismatches", mags_checked, mag_fail_count);
    if (mag_fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
